[rtl/min_max_pixel_normalizer_assert.svh]
// Assertion macros used by the top-level file that checks this block.
`ifndef MIN_MAX_PIXEL_NORMALIZER_ASSERT_SVH
`define MIN_MAX_PIXEL_NORMALIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMPN_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMPN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mmpn_pkg.sv]
`timescale 1ns / 1ps

package mmpn_pkg;

    localparam int MAX_PIXELS  = 65536;
    localparam int ADDR_W      = $clog2(MAX_PIXELS);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int PIX_W       = 16;
    localparam int NORM_W      = 8;
    localparam int NUM_W       = PIX_W + NORM_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int STEP_W      = $clog2(NORM_W);

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] min;
        logic [PIX_W-1:0] range;
        logic             last;
        logic             flat;
    } cmd_t;

endpackage

[rtl/mmpn_channels.sv]
`timescale 1ns / 1ps

interface mmpn_in_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [mmpn_pkg::PIX_W-1:0]  pixel_value;
    logic                        load_last;

    modport source (output valid, output req_type, output pixel_value, output load_last,
                    input ready);
    modport sink (input valid, input req_type, input pixel_value, input load_last,
                  output ready);
endinterface

interface mmpn_out_if;
    logic                        valid;
    logic                        ready;
    logic [mmpn_pkg::NORM_W-1:0] norm_value;
    logic                        out_last;
    logic                        flat_frame;

    modport source (output valid, output norm_value, output out_last, output flat_frame,
                    input ready);
    modport sink (input valid, input norm_value, input out_last, input flat_frame,
                  output ready);
endinterface

[rtl/mmpn_front.sv]
`timescale 1ns / 1ps

module mmpn_front (
    input  logic           clk,
    input  logic           rst_n,
    mmpn_in_if.sink        req,
    output logic           cmd_valid,
    output mmpn_pkg::cmd_t cmd,
    input  logic           cmd_ready
);

    logic [mmpn_pkg::PIX_W-1:0] mem [mmpn_pkg::MAX_PIXELS];

    logic                         pend_valid_reg;
    logic [mmpn_pkg::CNT_W-1:0]   count_reg;
    logic [mmpn_pkg::CNT_W-1:0]   rp_reg;
    logic [mmpn_pkg::PIX_W-1:0]   min_reg;
    logic [mmpn_pkg::PIX_W-1:0]   max_reg;
    logic                         done_reg;
    logic [mmpn_pkg::PIX_W-1:0]   rd_data_reg;
    logic [mmpn_pkg::PIX_W-1:0]   pmin_reg;
    logic [mmpn_pkg::PIX_W-1:0]   prange_reg;
    logic                         plast_reg;
    logic                         pflat_reg;

    logic                         accept;
    logic                         is_load;
    logic                         is_read;
    logic                         read_hit;
    logic                         push;
    logic                         full;
    logic [mmpn_pkg::CNT_W-1:0]   base_count;
    logic [mmpn_pkg::PIX_W-1:0]   base_min;
    logic [mmpn_pkg::PIX_W-1:0]   base_max;
    logic [mmpn_pkg::CNT_W-1:0]   rp_inc;

    assign push      = pend_valid_reg && cmd_ready;
    assign req.ready = !pend_valid_reg || cmd_ready;
    assign accept    = req.valid && req.ready;
    assign is_load   = accept && (req.req_type == mmpn_pkg::REQ_LOAD);
    assign is_read   = accept && (req.req_type == mmpn_pkg::REQ_READ);
    assign read_hit  = done_reg && (rp_reg < count_reg);
    assign rp_inc    = rp_reg + mmpn_pkg::CNT_W'(1);

    // A load after a closed frame starts a new frame before the pixel is taken.
    assign base_count = done_reg ? '0 : count_reg;
    assign base_min   = done_reg ? '1 : min_reg;
    assign base_max   = done_reg ? '0 : max_reg;
    assign full       = (base_count == mmpn_pkg::CNT_W'(mmpn_pkg::MAX_PIXELS));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            rp_reg         <= '0;
            min_reg        <= '1;
            max_reg        <= '0;
            done_reg       <= 1'b0;
        end else begin
            if (is_read && read_hit) begin
                pend_valid_reg <= 1'b1;
                rp_reg         <= rp_inc;
            end else if (push) begin
                pend_valid_reg <= 1'b0;
            end
            if (is_load) begin
                done_reg  <= req.load_last;
                count_reg <= base_count;
                min_reg   <= base_min;
                max_reg   <= base_max;
                if (done_reg) begin
                    rp_reg <= '0;
                end
                if (!full) begin
                    count_reg <= base_count + mmpn_pkg::CNT_W'(1);
                    if (req.pixel_value < base_min) begin
                        min_reg <= req.pixel_value;
                    end
                    if (req.pixel_value > base_max) begin
                        max_reg <= req.pixel_value;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (is_load && !full) begin
            mem[base_count[mmpn_pkg::ADDR_W-1:0]] <= req.pixel_value;
        end
        if (is_read && read_hit) begin
            rd_data_reg <= mem[rp_reg[mmpn_pkg::ADDR_W-1:0]];
            pmin_reg    <= min_reg;
            prange_reg  <= max_reg - min_reg;
            plast_reg   <= (rp_inc == count_reg);
            pflat_reg   <= (max_reg == min_reg);
        end
    end

    assign cmd_valid = pend_valid_reg;
    assign cmd.pix   = rd_data_reg;
    assign cmd.min   = pmin_reg;
    assign cmd.range = prange_reg;
    assign cmd.last  = plast_reg;
    assign cmd.flat  = pflat_reg;

endmodule

[rtl/mmpn_queue.sv]
`timescale 1ns / 1ps

module mmpn_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  mmpn_pkg::cmd_t push_data,
    output logic           push_ready,
    output logic           pop_valid,
    output mmpn_pkg::cmd_t pop_data,
    input  logic           pop_ready
);

    mmpn_pkg::cmd_t                entries [mmpn_pkg::QUEUE_DEPTH];
    logic [mmpn_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [mmpn_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [mmpn_pkg::QCNT_W-1:0]   cnt_reg;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = (cnt_reg != mmpn_pkg::QCNT_W'(mmpn_pkg::QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + mmpn_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + mmpn_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + mmpn_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - mmpn_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/mmpn_back.sv]
`timescale 1ns / 1ps

module mmpn_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  mmpn_pkg::cmd_t cmd,
    output logic           cmd_ready,
    mmpn_out_if.source     rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCALE,
        S_DIV,
        S_FINISH
    } state_t;

    state_t                        state_reg;
    logic                          out_valid_reg;
    logic [mmpn_pkg::PIX_W-1:0]    d_reg;
    logic [mmpn_pkg::PIX_W-1:0]    range_reg;
    logic [mmpn_pkg::NUM_W-1:0]    rem_reg;
    logic [mmpn_pkg::NUM_W-1:0]    div_reg;
    logic [mmpn_pkg::NORM_W-1:0]   q_reg;
    logic [mmpn_pkg::STEP_W-1:0]   step_reg;
    logic                          last_reg;
    logic                          flat_reg;
    logic [mmpn_pkg::NORM_W-1:0]   norm_out_reg;
    logic                          last_out_reg;
    logic                          flat_out_reg;

    logic [mmpn_pkg::NUM_W:0]      trial;
    logic                          fits;
    logic                          out_free;
    logic                          take;
    logic                          emit;

    assign trial     = {1'b0, rem_reg} - {1'b0, div_reg};
    assign fits      = !trial[mmpn_pkg::NUM_W];
    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign take      = cmd_valid && cmd_ready;
    assign emit      = (state_reg == S_FINISH) && out_free;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (rsp.ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (cmd_valid) begin
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    state_reg <= flat_reg ? S_FINISH : S_DIV;
                end
                S_DIV: begin
                    if (step_reg == '0) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The quotient never exceeds 255, so eight restoring steps cover it.
    always_ff @(posedge clk) begin
        if (take) begin
            d_reg     <= (cmd.pix >= cmd.min) ? cmd.pix - cmd.min : '0;
            range_reg <= cmd.range;
            last_reg  <= cmd.last;
            flat_reg  <= cmd.flat;
        end
        if (state_reg == S_SCALE) begin
            rem_reg  <= {d_reg, mmpn_pkg::NORM_W'(0)} - mmpn_pkg::NUM_W'(d_reg);
            div_reg  <= mmpn_pkg::NUM_W'({range_reg, (mmpn_pkg::NORM_W - 1)'(0)});
            q_reg    <= '0;
            step_reg <= mmpn_pkg::STEP_W'(mmpn_pkg::NORM_W - 1);
        end
        if (state_reg == S_DIV) begin
            if (fits) begin
                rem_reg <= trial[mmpn_pkg::NUM_W-1:0];
            end
            div_reg  <= div_reg >> 1;
            q_reg    <= {q_reg[mmpn_pkg::NORM_W-2:0], fits};
            step_reg <= step_reg - mmpn_pkg::STEP_W'(1);
        end
        if (emit) begin
            norm_out_reg <= q_reg;
            last_out_reg <= last_reg;
            flat_out_reg <= flat_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.norm_value = norm_out_reg;
    assign rsp.out_last   = last_out_reg;
    assign rsp.flat_frame = flat_out_reg;

endmodule

[rtl/min_max_pixel_normalizer.sv]
// Contrast stretch of one frame of 16-bit pixels down to 8 bits.
// The req channel carries transactions of two kinds. A load (req_type 0)
// stores pixel_value in the frame store and updates the frame minimum and
// maximum; load_last closes the frame. A read (req_type 1) on a closed frame
// returns the next stored pixel as (pixel - min) * 255 / (max - min) on the
// rsp channel, with out_last on the final pixel and flat_frame (value 0) when
// max equals min. Loads and reads that produce nothing return no transaction.
// Loads are taken one per cycle while req.ready is high. A read result goes
// from the frame store through the queue to the back end, which scales it
// and runs its eight-step restoring divider (skipped on a flat frame). The
// back end takes no new result until the last has left for the output
// register. A four-entry queue lets the front keep accepting reads while
// the divider works. When the receiver stalls, the result holds in the
// output register, the divider and then the queue fill, and req.ready drops.
// Reset empties the queue, clears any pending result and starts a new frame;
// the frame store itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

`include "min_max_pixel_normalizer_assert.svh"

module min_max_pixel_normalizer (
    input  logic      clk,
    input  logic      rst_n,
    mmpn_in_if.sink   req,
    mmpn_out_if.source rsp
);

    logic           front_valid;
    mmpn_pkg::cmd_t front_cmd;
    logic           front_ready;
    logic           back_valid;
    mmpn_pkg::cmd_t back_cmd;
    logic           back_ready;

    mmpn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_ready (front_ready)
    );

    mmpn_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_data  (front_cmd),
        .push_ready (front_ready),
        .pop_valid  (back_valid),
        .pop_data   (back_cmd),
        .pop_ready  (back_ready)
    );

    mmpn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd       (back_cmd),
        .cmd_ready (back_ready),
        .rsp       (rsp)
    );

    `MMPN_ASSERT_SAME(a_flat_is_zero, clk, rst_n, rsp.valid && rsp.flat_frame,
        rsp.norm_value == '0, "flat frame result is not zero")
    `MMPN_ASSERT_NEXT(a_front_holds, clk, rst_n, front_valid && !front_ready,
        front_valid && $stable(front_cmd), "front dropped a stalled command")
    `MMPN_ASSERT_SAME(a_stall_blocks_req, clk, rst_n, front_valid && !front_ready,
        !req.ready, "front accepts while its command is stalled")

endmodule
